### design/suks_pkg.sv
// Shared types and codes for the sorted unique key set.
package suks_pkg;

    localparam int KEY_HIGH_W = 64;
    localparam int KEY_LOW_W  = 56;
    localparam int KEY_BYTES  = 15;

    typedef struct packed {
        logic [KEY_HIGH_W-1:0] high;
        logic [KEY_LOW_W-1:0]  low;
    } t_key;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic cmp;    // register compare flags against the broadcast key
        logic ins;    // open a slot at the insert point and shift up
        logic drain;  // shift every cell down by one
        logic clear;  // drop every key
    } t_cell_ctl;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DRAIN  = 2'd1;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_DRAINED  = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

endpackage

### design/suks_cell.sv
// One slot of the sorted chain: holds a key, compares and shifts with its neighbors.
module suks_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  suks_pkg::t_cell_ctl i_ctl,
    input  suks_pkg::t_key      i_new_key,
    input  suks_pkg::t_key      i_left_key,
    input  logic                i_left_valid,
    input  logic                i_left_lt,
    input  suks_pkg::t_key      i_right_key,
    input  logic                i_right_valid,
    output suks_pkg::t_key      o_key,
    output logic                o_valid,
    output logic                o_lt,
    output logic                o_eq
);
    import suks_pkg::*;

    t_key r_key;
    logic r_valid;
    logic r_lt;
    logic r_eq;
    logic n_lt;
    logic n_eq;

    // empty slots rank above every key
    assign n_lt = !r_valid || (i_new_key < r_key);
    assign n_eq = r_valid && (i_new_key == r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lt    <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_lt <= n_lt;
                r_eq <= n_eq;
            end
            if (i_ctl.clear) begin
                r_valid <= 1'b0;
            end else if (i_ctl.drain) begin
                r_valid <= i_right_valid;
            end else if (i_ctl.ins && r_lt) begin
                r_valid <= i_left_lt ? i_left_valid : 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.drain) begin
            r_key <= i_right_key;
        end else if (i_ctl.ins && r_lt) begin
            r_key <= i_left_lt ? i_left_key : i_new_key;
        end
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

### design/sorted_unique_key_set.sv
// Top level of the sorted unique key set: request control and the chain of key cells.
//
// Usage
//   Input channel (i_valid / o_stall) carries one request: i_cmd selects insert,
//   drain of the smallest key, or clear (either code with the high bit set).
//   Keys are two fields, first character in the top byte; a key ends at its
//   first NUL and at KEY_CHARS characters, later bytes are zeroed.
//   Output channel (o_valid / i_stall) returns exactly one result per request:
//   status, drained key (zero unless drained), last flag and the key count.
// Timing
//   A request is taken in idle, the cells register their compare flags in
//   the next cycle, and the chain updates and the result register loads in
//   the execute state once the output register is free. The cell chain has
//   a compare stage followed by a shift stage and handles one request at a
//   time: the next request is taken only after the chain has updated.
// Stall
//   A new request is taken while a result still waits in the output
//   register; the update stage holds until that register frees up.
// Reset
//   Synchronous, active low: the set is empty and no result is pending.
//   Key storage is not cleared; empty slots are marked by their valid bits.
module sorted_unique_key_set #(
    parameter int CAPACITY  = 64,
    parameter int KEY_CHARS = 15
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [1:0]   i_cmd,
    input  logic [63:0]  i_key_high,
    input  logic [55:0]  i_key_low,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [2:0]   o_status,
    output logic [63:0]  o_out_key_high,
    output logic [55:0]  o_out_key_low,
    output logic         o_is_last,
    output logic [6:0]   o_count_after
);
    import suks_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state         r_state;
    t_state         n_state;
    logic [1:0]     r_cmd;
    t_key           r_key;
    t_key           n_key;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic           r_out_valid;
    logic [2:0]     r_status;
    logic [2:0]     n_status;
    t_key           r_out_key;
    t_key           n_out_key;
    logic           r_is_last;
    logic           n_is_last;
    logic [6:0]     r_count_after;

    t_cell_ctl      w_ctl;
    t_key           w_cell_key   [CAPACITY];
    logic           w_cell_valid [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;

    logic           w_accept;
    logic           w_exec;
    logic           w_dup;
    logic           w_full;
    logic           w_empty;

    // ---- key normalization: zero everything from the first NUL or char limit on
    always_comb begin
        logic [8*KEY_BYTES-1:0] flat;
        logic                   ended;
        flat  = {i_key_high, i_key_low};
        ended = 1'b0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (b >= KEY_CHARS || flat[8*KEY_BYTES-1-8*b -: 8] == 8'd0) begin
                ended = 1'b1;
            end
            if (ended) begin
                flat[8*KEY_BYTES-1-8*b -: 8] = 8'd0;
            end
        end
        n_key.high = flat[8*KEY_BYTES-1 -: KEY_HIGH_W];
        n_key.low  = flat[KEY_LOW_W-1:0];
    end

    // ---- handshake
    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_exec   = (r_state == S_EXEC) && (!r_out_valid || !i_stall);

    assign w_dup   = |w_eq;
    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_empty = (r_count == '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_exec) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---- command decode for the update cycle
    always_comb begin
        w_ctl      = '0;
        w_ctl.cmp  = (r_state == S_CMP);
        n_count    = r_count;
        n_status   = ST_EMPTY;
        n_out_key  = '0;
        n_is_last  = 1'b0;
        if (r_cmd[1]) begin
            w_ctl.clear = w_exec;
            n_count     = '0;
        end else if (r_cmd == CMD_DRAIN) begin
            if (!w_empty) begin
                w_ctl.drain = w_exec;
                n_count     = r_count - CW'(1);
                n_status    = ST_DRAINED;
                n_out_key   = w_cell_key[0];
                n_is_last   = (r_count == CW'(1));
            end
        end else begin
            priority if (w_dup) begin
                n_status = ST_DUP;
            end else if (w_full) begin
                n_status = ST_FULL;
            end else begin
                w_ctl.ins = w_exec;
                n_count   = r_count + CW'(1);
                n_status  = ST_INSERTED;
            end
        end
    end

    // ---- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
            r_key <= n_key;
        end
        if (w_exec) begin
            r_status      <= n_status;
            r_out_key     <= n_out_key;
            r_is_last     <= n_is_last;
            r_count_after <= 7'(n_count);
        end
    end

    // ---- cell chain: slot 0 holds the smallest key
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_key w_left_key;
        logic w_left_valid;
        logic w_left_lt;
        t_key w_right_key;
        logic w_right_valid;

        if (g == 0) begin : g_head
            assign w_left_key   = r_key;
            assign w_left_valid = 1'b1;
            assign w_left_lt    = 1'b0;
        end else begin : g_body
            assign w_left_key   = w_cell_key[g-1];
            assign w_left_valid = w_cell_valid[g-1];
            assign w_left_lt    = w_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_key   = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right_key   = w_cell_key[g+1];
            assign w_right_valid = w_cell_valid[g+1];
        end

        suks_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_new_key     (r_key),
            .i_left_key    (w_left_key),
            .i_left_valid  (w_left_valid),
            .i_left_lt     (w_left_lt),
            .i_right_key   (w_right_key),
            .i_right_valid (w_right_valid),
            .o_key         (w_cell_key[g]),
            .o_valid       (w_cell_valid[g]),
            .o_lt          (w_lt[g]),
            .o_eq          (w_eq[g])
        );
    end

    // ---- outputs
    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_out_key_high = r_out_key.high;
    assign o_out_key_low  = r_out_key.low;
    assign o_is_last      = r_is_last;
    assign o_count_after  = r_count_after;

endmodule

### test/tb.sv
// Self-checking testbench for the sorted unique key set: queued driver, monitor, set predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import suks_pkg::*;

    localparam int SET_DEPTH    = 64;
    localparam int KEY_CHARS    = 15;
    localparam int PHASE_ITEMS  = 476;   // random requests per idling phase
    localparam int HOLD_CYCLES  = 60;    // long receiver hold-off, fills the block
    localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 8;     // settle time after the last result

    // clear is any code with the high bit set; 3 is the unused alias
    localparam logic [1:0] CMD_CLEAR    = 2'd2;
    localparam logic [1:0] CMD_CLEAR_HI = 2'd3;

    // a key as one 120-bit word: first character in the top byte, so an
    // unsigned compare of the word gives strcmp order
    typedef logic [119:0] t_flat_key;

    typedef struct packed {
        logic [1:0] cmd;
        t_flat_key  key;
    } t_key_req;

    typedef struct packed {
        logic [2:0] status;
        t_flat_key  key;
        logic       is_last;
        logic [6:0] count;
    } t_set_result;

    // request mix of one stretch of random traffic
    typedef enum int {EP_FILL, EP_EMPTY, EP_MIXED, EP_DUPS} t_episode;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_valid = 1'b0;
    logic         o_stall;
    logic [1:0]   i_cmd = CMD_INSERT;
    logic [63:0]  i_key_high = '0;
    logic [55:0]  i_key_low = '0;
    logic         o_valid;
    logic         i_stall = 1'b0;
    logic [2:0]   o_status;
    logic [63:0]  o_out_key_high;
    logic [55:0]  o_out_key_low;
    logic         o_is_last;
    logic [6:0]   o_count_after;

    t_key_req     request_queue[$];   // requests not yet put on the bus
    t_set_result  pending_results[$]; // predicted results, oldest first
    t_flat_key    held_keys[$];       // predictor's copy of the set, ascending

    t_flat_key    word_pool[32];      // recurring keys, for duplicates
    int           word_len[32];

    int  sent_count = 0;
    int  taken_count = 0;
    int  fault_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  req_taken = 1'b0;    // request handshake at the last rising edge
    bit  hold_request = 1'b0; // ask the receiver for one long hold-off
    int  hold_left = 0;
    int  quiet_cycles = 0;

    sorted_unique_key_set #(
        .CAPACITY  (SET_DEPTH),
        .KEY_CHARS (KEY_CHARS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_key_high     (i_key_high),
        .i_key_low      (i_key_low),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_out_key_high (o_out_key_high),
        .o_out_key_low  (o_out_key_low),
        .o_is_last      (o_is_last),
        .o_count_after  (o_count_after)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Set predictor
    // ---------------------------------------------------------------

    // Key ends at the first NUL or after KEY_CHARS characters; every byte
    // past the end reads as zero, for compare and for storage.
    function automatic t_flat_key trim_key(t_flat_key k);
        bit ended;
        ended = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (i >= KEY_CHARS || k[119 - 8*i -: 8] == 8'h00) ended = 1'b1;
            if (ended) k[119 - 8*i -: 8] = 8'h00;
        end
        return k;
    endfunction

    // Applies one request to held_keys and returns the result it causes.
    function automatic t_set_result predict_set_result(t_key_req rq);
        t_set_result r;
        t_flat_key   k;
        int          pos;
        bit          dup;
        r = '0;
        if (rq.cmd[1]) begin
            // clear, whichever of the two codes
            held_keys.delete();
            r.status = ST_EMPTY;
        end else if (rq.cmd == CMD_DRAIN) begin
            if (held_keys.size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.key     = held_keys.pop_front();
                r.is_last = (held_keys.size() == 0);
                r.status  = ST_DRAINED;
            end
        end else begin
            k   = trim_key(rq.key);
            pos = held_keys.size();
            dup = 1'b0;
            for (int i = 0; i < held_keys.size(); i++) begin
                if (k == held_keys[i]) begin
                    dup = 1'b1;
                    break;
                end
                if (k < held_keys[i]) begin
                    pos = i;
                    break;
                end
            end
            if (dup) begin
                r.status = ST_DUP;
            end else if (held_keys.size() >= SET_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                held_keys.insert(pos, k);
                r.status = ST_INSERTED;
            end
        end
        r.count = 7'(held_keys.size());
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    task automatic queue_request(input logic [1:0] cmd, input t_flat_key key);
        request_queue.push_back('{cmd: cmd, key: key});
        sent_count++;
    endtask

    // Clean key of len characters: mostly a small alphabet so prefixes
    // collide and the compare reaches the low field, sometimes any byte.
    function automatic t_flat_key spell_key(int len);
        t_flat_key k;
        k = '0;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 70) k[119 - 8*i -: 8] = 8'h61 + 8'($urandom_range(7));
            else k[119 - 8*i -: 8] = 8'($urandom_range(255, 1));
        end
        return k;
    endfunction

    // Junk after the terminating NUL; must not change the key.
    function automatic t_flat_key add_tail_noise(t_flat_key k, int len);
        for (int i = len + 1; i < KEY_BYTES; i++) k[119 - 8*i -: 8] = 8'($urandom_range(255));
        return k;
    endfunction

    function automatic t_flat_key pick_insert_key(int pool_pct);
        t_flat_key k;
        int        len;
        int        slot;
        if ($urandom_range(99) < pool_pct) begin
            slot = $urandom_range(31);
            k    = word_pool[slot];
            len  = word_len[slot];
        end else begin
            len = $urandom_range(99);
            if (len < 2) len = 0;
            else if (len < 15) len = KEY_BYTES;
            else len = $urandom_range(14, 1);
            k = spell_key(len);
        end
        if ($urandom_range(1)) k = add_tail_noise(k, len);
        return k;
    endfunction

    // Random traffic in stretches: filling runs push the set to capacity,
    // emptying runs drain it to the last key, duplicate runs recycle keys.
    task automatic add_random_requests(input int total);
        t_episode   mode;
        int         left;
        int         span;
        int         roll;
        int         ins_pct;
        int         drn_pct;
        logic [1:0] cmd;
        t_flat_key  key;
        left = total;
        while (left > 0) begin
            mode = t_episode'($urandom_range(3));
            span = $urandom_range(140, 30);
            case (mode)
                EP_FILL: begin
                    ins_pct = 85; drn_pct = 99;
                end
                EP_EMPTY: begin
                    ins_pct = 15; drn_pct = 98;
                end
                EP_MIXED: begin
                    ins_pct = 55; drn_pct = 95;
                end
                default: begin
                    ins_pct = 75; drn_pct = 97;
                end
            endcase
            for (int j = 0; j < span && left > 0; j++) begin
                roll = $urandom_range(99);
                if (roll < ins_pct) begin
                    cmd = CMD_INSERT;
                    key = pick_insert_key(mode == EP_DUPS ? 90 : 30);
                end else begin
                    if (roll < drn_pct) cmd = CMD_DRAIN;
                    else cmd = $urandom_range(1) ? CMD_CLEAR : CMD_CLEAR_HI;
                    // key fields are don't-care here, so drive junk
                    key = t_flat_key'({$urandom, $urandom, $urandom, $urandom});
                end
                queue_request(cmd, key);
                left--;
            end
        end
    endtask

    task automatic add_directed_requests();
        // empty set: drain and clear both say empty
        queue_request(CMD_DRAIN, '1);
        queue_request(CMD_CLEAR, '0);
        // extremes: empty string and fifteen 0xFF characters
        queue_request(CMD_INSERT, '0);
        queue_request(CMD_INSERT, '1);
        queue_request(CMD_INSERT, '1);
        // leading NUL with junk behind it is the empty string again
        queue_request(CMD_INSERT, {8'h00, {112{1'b1}}});
        // junk after the NUL must not split one key into two
        queue_request(CMD_INSERT, {"ab", 8'h00, {12{8'hA5}}});
        queue_request(CMD_INSERT, {"ab", 104'h0});
        // full length keys differing only in the last character, then keys filling just the high field
        queue_request(CMD_INSERT, "abcdefghijklmno");
        queue_request(CMD_INSERT, "abcdefghijklmnp");
        queue_request(CMD_INSERT, {"abcdefgh", 56'h0});
        queue_request(CMD_INSERT, {64'hFFFF_FFFF_FFFF_FFFF, 56'h0});
        // drains come out smallest first
        queue_request(CMD_DRAIN, '0);
        queue_request(CMD_DRAIN, '1);
        // unused code acts as clear
        queue_request(CMD_CLEAR_HI, {60{2'b10}});
        queue_request(CMD_DRAIN, {60{2'b01}});
        // single key: its drain carries the last flag
        queue_request(CMD_INSERT, {"z", 112'h0});
        queue_request(CMD_DRAIN, '0);
        // out-of-order arrivals
        queue_request(CMD_INSERT, {"m", 112'h0});
        queue_request(CMD_INSERT, {"c", 112'h0});
        queue_request(CMD_INSERT, {"x", 112'h0});
        queue_request(CMD_DRAIN, '0);
        queue_request(CMD_CLEAR, '1);
    endtask

    // ---------------------------------------------------------------
    // Driver: new request at the falling edge once the bus is free
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        t_key_req nxt;
        if (i_rst_n && (!i_valid || req_taken)) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = request_queue.pop_front();
                i_valid    <= 1'b1;
                i_cmd      <= nxt.cmd;
                i_key_high <= nxt.key[119:56];
                i_key_low  <= nxt.key[55:0];
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall, or a counted hold-off when asked for one.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: check results, predict accepted requests
    // ---------------------------------------------------------------
    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            fault_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_set_result want;
        req_taken = i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t ns: expected no result, actual status %0d count %0d",
                             $time, o_status, o_count_after);
                    fault_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("status", 64'(want.status), 64'(o_status));
                    compare_field("out_key_high", want.key[119:56], o_out_key_high);
                    compare_field("out_key_low", 64'(want.key[55:0]), 64'(o_out_key_low));
                    compare_field("is_last", 64'(want.is_last), 64'(o_is_last));
                    compare_field("count_after", 64'(want.count), 64'(o_count_after));
                end
            end
            if (req_taken) begin
                pending_results.push_back(predict_set_result('{cmd: i_cmd,
                                          key: {i_key_high, i_key_low}}));
                taken_count++;
            end
        end
    end

    // Watchdog: too long without any handshake means the block hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Sequence: reset, three idling phases, final verdict
    // ---------------------------------------------------------------
    initial begin
        for (int i = 0; i < 32; i++) begin
            word_len[i]  = (i % 8 == 0) ? KEY_BYTES : $urandom_range(14, 1);
            word_pool[i] = spell_key(word_len[i]);
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            @(posedge i_clk);
            // sender-light/receiver-heavy, then swapped, then flat out
            case (phase)
                0: begin
                    send_idle_pct = 19; recv_idle_pct = 62;
                end
                1: begin
                    send_idle_pct = 62; recv_idle_pct = 19;
                end
                default: begin
                    send_idle_pct = 0; recv_idle_pct = 0;
                end
            endcase
            if (phase == 0) add_directed_requests();
            add_random_requests(PHASE_ITEMS);
            // back-pressure while the queue is full, so the input stalls
            hold_request = 1'b1;
            while (taken_count != sent_count || pending_results.size() != 0) begin
                @(negedge i_clk);
            end
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
